// File: src/set_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Used by set_line, set_grad, set_ofifo and sobel_edge_threshold; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package set_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;

  // Register field widths
  localparam int CFG_W_W   = 11;
  localparam int HGT_W     = 16;
  localparam int THR_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_W_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [HGT_W-1:0]   HEIGHT_RST    = 16'd480;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 11'd64;

  // Pixel and arithmetic widths
  localparam int PIX_W  = 8;
  localparam int GX_W   = 14;  // 3/6/3 horizontal gradient, |gx2| <= 3060
  localparam int GY_W   = 12;  // 1/2/1 vertical gradient, |gy| <= 1020
  localparam int M4_W   = 25;  // gx2^2 + 4*gy^2
  localparam int K_W    = THR_W - 1;
  localparam int THR4_W = 2 * K_W + 2;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  // Result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam int BUSY_W     = 3;  // in-flight item count, up to four stages

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: top, middle and bottom rows
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic emit_a;  // result for the previous column
    logic emit_b;  // extra result for the last column
    logic sel_a;   // previous column is the first: replicate left edge
    logic sel_b;   // row is one pixel wide: replicate left edge
    logic last;    // last column of the row
    logic flush;   // flush row
  } ctl_t;

  // Line store request for one accepted pixel
  typedef struct packed {
    logic [COL_W-1:0] x;
    pix_t             pixel;
    logic             top_is_mid;
    ctl_t             ctl;
  } req_t;

  // One result word
  typedef struct packed {
    pix_t edge_res;
    logic last_in_run;
    logic frame_done;
  } res_t;

endpackage

`default_nettype wire

// File: src/set_line.sv
// Line stores and 3x3 window for the Sobel edge threshold block.
// Two single-port-write, one-read memories with read-modify-write forwarding; uses set_pkg.
`timescale 1ns / 1ps
`default_nettype none

module set_line
  import set_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic req_valid,
  input  wire req_t req,
  output logic      win_valid,
  output ctl_t      win_ctl,
  output col_t      win_col [3],
  output logic [1:0] busy
);

  pix_t older_mem  [MAX_WIDTH];
  pix_t recent_mem [MAX_WIDTH];

  logic             v1_r;
  logic [COL_W-1:0] x1_r;
  pix_t             p1_r;
  logic             tm1_r;
  ctl_t             ctl1_r;
  pix_t             rd_recent_r;
  pix_t             rd_older_r;
  logic             fwd_r;
  pix_t             fwd_recent_r;
  pix_t             fwd_older_r;
  logic             v2_r;
  ctl_t             ctl2_r;
  col_t             win_r [3];

  pix_t mid;
  pix_t older;
  col_t col_new;

  // Memory read at accept, write-back in the following cycle
  always_ff @(posedge clk) begin
    if (req_valid) begin
      rd_recent_r <= recent_mem[req.x];
      rd_older_r  <= older_mem[req.x];
    end
    if (v1_r) begin
      recent_mem[x1_r] <= p1_r;
      older_mem[x1_r]  <= mid;
    end
  end

  // Merge forwarded data from the write-back still in flight
  always_comb begin
    mid         = fwd_r ? fwd_recent_r : rd_recent_r;
    older       = fwd_r ? fwd_older_r : rd_older_r;
    col_new.mid = mid;
    col_new.top = tm1_r ? mid : older;
    col_new.bot = ctl1_r.flush ? mid : p1_r;
  end

  // Advance the read stage and capture forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      v1_r <= req_valid;
      if (req_valid) begin
        fwd_r <= v1_r && (x1_r == req.x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      x1_r         <= req.x;
      p1_r         <= req.pixel;
      tm1_r        <= req.top_is_mid;
      ctl1_r       <= req.ctl;
      fwd_recent_r <= p1_r;
      fwd_older_r  <= mid;
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= col_new;
      ctl2_r   <= ctl1_r;
    end
  end

  assign win_valid = v2_r;
  assign win_ctl   = ctl2_r;
  assign win_col   = win_r;
  assign busy      = {v2_r, v1_r};

endmodule

`default_nettype wire

// File: src/set_grad.sv
// Gradient, squared magnitude and threshold compare for two result lanes.
// Gradient and square register stages fed by the window of set_line; uses set_pkg.
`timescale 1ns / 1ps
`default_nettype none

module set_grad
  import set_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             win_valid,
  input  wire ctl_t             win_ctl,
  input  wire col_t             win_col [3],
  input  wire logic [THR_W-1:0] threshold,
  output logic                  push_a,
  output res_t                  res_a,
  output logic                  push_b,
  output res_t                  res_b,
  output logic [1:0]            busy
);

  function automatic logic signed [GX_W-1:0] pix_ext(pix_t p);
    return $signed({{(GX_W-PIX_W){1'b0}}, p});
  endfunction

  function automatic logic signed [GX_W-1:0] grad_x2(col_t l, col_t r);
    logic signed [GX_W-1:0] dt;
    logic signed [GX_W-1:0] dm;
    logic signed [GX_W-1:0] db;
    dt = pix_ext(l.top) - pix_ext(r.top);
    dm = pix_ext(l.mid) - pix_ext(r.mid);
    db = pix_ext(l.bot) - pix_ext(r.bot);
    return (dt <<< 1) + dt + (dm <<< 2) + (dm <<< 1) + (db <<< 1) + db;
  endfunction

  function automatic logic signed [GY_W-1:0] grad_y(col_t l, col_t c, col_t r);
    logic signed [GY_W-1:0] t;
    logic signed [GY_W-1:0] b;
    t = GY_W'(pix_ext(l.top)) + (GY_W'(pix_ext(c.top)) <<< 1) + GY_W'(pix_ext(r.top));
    b = GY_W'(pix_ext(l.bot)) + (GY_W'(pix_ext(c.bot)) <<< 1) + GY_W'(pix_ext(r.bot));
    return t - b;
  endfunction

  logic                   vg_r;
  ctl_t                   ctlg_r;
  logic signed [GX_W-1:0] gxa_r;
  logic signed [GY_W-1:0] gya_r;
  logic signed [GX_W-1:0] gxb_r;
  logic signed [GY_W-1:0] gyb_r;
  logic                   vm_r;
  ctl_t                   ctlm_r;
  logic [M4_W-1:0]        m4a_r;
  logic [M4_W-1:0]        m4b_r;
  logic [THR4_W-1:0]      thr4_r;

  col_t                     la;
  col_t                     lb;
  logic signed [2*GX_W-1:0] sqxa;
  logic signed [2*GY_W-1:0] sqya;
  logic signed [2*GX_W-1:0] sqxb;
  logic signed [2*GY_W-1:0] sqyb;
  logic [K_W-1:0]           k;
  logic [2*K_W-1:0]         kk;
  logic                     hit_a;
  logic                     hit_b;

  // Replicate the left border where the window has no older column
  always_comb begin
    la = win_ctl.sel_a ? win_col[1] : win_col[0];
    lb = win_ctl.sel_b ? win_col[2] : win_col[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
      vm_r <= 1'b0;
    end else begin
      vg_r <= win_valid;
      vm_r <= vg_r;
    end
  end

  // Gradient stage
  always_ff @(posedge clk) begin
    if (win_valid) begin
      ctlg_r <= win_ctl;
      gxa_r  <= grad_x2(la, win_col[2]);
      gya_r  <= grad_y(la, win_col[1], win_col[2]);
      gxb_r  <= grad_x2(lb, win_col[2]);
      gyb_r  <= grad_y(lb, win_col[2], win_col[2]);
    end
  end

  // Square stage: gx2^2 + 4*gy^2
  always_comb begin
    sqxa = gxa_r * gxa_r;
    sqya = gya_r * gya_r;
    sqxb = gxb_r * gxb_r;
    sqyb = gyb_r * gyb_r;
  end

  always_ff @(posedge clk) begin
    if (vg_r) begin
      ctlm_r <= ctlg_r;
      m4a_r  <= M4_W'(sqxa) + M4_W'({sqya, 2'b00});
      m4b_r  <= M4_W'(sqxb) + M4_W'({sqyb, 2'b00});
    end
  end

  // Threshold bound 4*floor(T/2)^2
  always_comb begin
    k  = threshold[THR_W-1:1];
    kk = k * k;
  end

  always_ff @(posedge clk) begin
    thr4_r <= {kk, 2'b00};
  end

  // Compare and form result words
  always_comb begin
    hit_a             = m4a_r > M4_W'(thr4_r);
    hit_b             = m4b_r > M4_W'(thr4_r);
    push_a            = vm_r && ctlm_r.emit_a;
    push_b            = vm_r && ctlm_r.emit_b;
    res_a.edge_res    = hit_a ? EDGE_ON : EDGE_OFF;
    res_a.last_in_run = !ctlm_r.last;
    res_a.frame_done  = 1'b0;
    res_b.edge_res    = hit_b ? EDGE_ON : EDGE_OFF;
    res_b.last_in_run = 1'b1;
    res_b.frame_done  = ctlm_r.flush;
  end

  assign busy = {vm_r, vg_r};

endmodule

`default_nettype wire

// File: src/set_ofifo.sv
// Result queue taking up to two words per cycle and giving one while the receiver is ready.
// Register-file queue with count; uses set_pkg.
`timescale 1ns / 1ps
`default_nettype none

module set_ofifo
  import set_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_a,
  input  wire res_t        res_a,
  input  wire logic        push_b,
  input  wire res_t        res_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res,
  output logic [FIFO_CW-1:0] count
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r;
  logic [FIFO_AW-1:0] rp_r;
  logic [FIFO_CW-1:0] cnt_r;

  logic               pop;
  logic [FIFO_AW-1:0] wp_inc;

  assign pop    = out_valid && out_ready;
  assign wp_inc = wp_r + 1'b1;

  // Store in order: lane A ahead of lane B
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wp_r] <= res_a;
      if (push_b) begin
        mem_r[wp_inc] <= res_b;
      end
    end else if (push_b) begin
      mem_r[wp_r] <= res_b;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_AW'(push_a) + FIFO_AW'(push_b);
      rp_r  <= rp_r + FIFO_AW'(pop);
      cnt_r <= cnt_r + FIFO_CW'(push_a) + FIFO_CW'(push_b) - FIFO_CW'(pop);
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign count     = cnt_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[FIFO_AW-1:0] == FIFO_AW'(wp_r - rp_r))
    else $error("queue pointers disagree with count");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 && (push_a || push_b)) |=> out_valid)
    else $error("pushed word not presented");
`endif

endmodule

`default_nettype wire

// File: src/sobel_edge_threshold.sv
// Top level of the Sobel edge threshold block: registers, raster counters, flow control.
// Instantiates set_line, set_grad and set_ofifo; uses set_pkg.
//
// Usage:
//   in_*  : one 8-bit grey pixel per word, raster order. After image_height rows send
//           one more row of image_width words (values ignored) to flush the bottom row.
//   out_* : one word per output pixel, 0 or 255 in out_tdata[7:0]; out_tlast marks the
//           last word caused by an input word, out_tuser marks the last pixel of a frame.
//   cfg_* : register writes (index 0 width, 1 height, 2 threshold); always ready.
//           Write only while no image is in progress.
// Throughput: one pixel per clock while the queue has room; each line store has one read
//   and one write port, and every pixel does one read and one write-back per store.
// Order: output row y-1 is produced while row y arrives; pixel (x, y-1) leaves from
//   input (x+1, y) through the read, window, gradient and square registers and the queue.
//   Input (w-1, y) also yields the last column, one word behind column w-2.
// Reset: counters, registers and queue clear at once; the line stores are not
//   cleared and need no clearing pass, as no unwritten entry reaches a result.
// Stall: a 16-word result queue absorbs results; in_tready drops when the queue
//   plus words still in the pipeline could overflow it.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold
  import set_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] pixel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [7:0] edge_res
  output logic                      out_tlast,  // last_in_run
  output logic                      out_tuser,  // [0] frame_done
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [CFG_W_W-1:0] width_r;
  logic [HGT_W-1:0]   height_r;
  logic [THR_W-1:0]   thr_r;
  logic [COL_W-1:0]   col_r;
  logic [HGT_W-1:0]   row_r;

  logic               acc;
  logic [WID_W-1:0]   w_eff;
  logic [HGT_W-1:0]   h_eff;
  logic [WID_W-1:0]   x_wide;
  logic [COL_W-1:0]   x;
  logic               flush;
  logic               last;
  req_t               req;

  logic               win_valid;
  ctl_t               win_ctl;
  col_t               win_col [3];
  logic [1:0]         line_busy;
  logic [1:0]         grad_busy;
  logic               push_a;
  logic               push_b;
  res_t               res_a;
  res_t               res_b;
  res_t               out_res;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [BUSY_W-1:0]  inflight;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thr_r    <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:     width_r  <= cfg_data[CFG_W_W-1:0];
        REG_HEIGHT:    height_r <= cfg_data[HGT_W-1:0];
        REG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp geometry and locate the current pixel
  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_r);
    end
    h_eff  = (height_r == '0) ? HGT_W'(1) : height_r;
    x_wide = (WID_W'(col_r) >= w_eff) ? (w_eff - 1'b1) : WID_W'(col_r);
    x      = x_wide[COL_W-1:0];
    flush  = (row_r >= h_eff);
    last   = (x_wide == w_eff - 1'b1);
  end

  always_comb begin
    req.x              = x;
    req.pixel          = in_tdata[PIX_W-1:0];
    req.top_is_mid     = (row_r <= HGT_W'(1));
    req.ctl.emit_a     = (row_r != '0) && (x != '0);
    req.ctl.emit_b     = (row_r != '0) && last;
    req.ctl.sel_a      = (x == COL_W'(1));
    req.ctl.sel_b      = (x == '0);
    req.ctl.last       = last;
    req.ctl.flush      = flush;
  end

  // Hold input while the queue could not take every pending result
  assign inflight  = BUSY_W'($countones({line_busy, grad_busy}));
  assign in_tready = ({1'b0, fifo_cnt} + {2'b00, inflight, 1'b0})
                     <= (FIFO_CW + 1)'(FIFO_DEPTH - 2);
  assign acc       = in_tvalid && in_tready;

  // Advance column and row counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (last) begin
        col_r <= '0;
        row_r <= flush ? '0 : row_r + 1'b1;
      end else begin
        col_r <= x + 1'b1;
      end
    end
  end

  set_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (acc),
    .req       (req),
    .win_valid (win_valid),
    .win_ctl   (win_ctl),
    .win_col   (win_col),
    .busy      (line_busy)
  );

  set_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_valid (win_valid),
    .win_ctl   (win_ctl),
    .win_col   (win_col),
    .threshold (thr_r),
    .push_a    (push_a),
    .res_a     (res_a),
    .push_b    (push_b),
    .res_b     (res_b),
    .busy      (grad_busy)
  );

  set_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .res_a     (res_a),
    .push_b    (push_b),
    .res_b     (res_b),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .count     (fifo_cnt)
  );

  assign out_tdata = out_res.edge_res;
  assign out_tlast = out_res.last_in_run;
  assign out_tuser = out_res.frame_done;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for sobel_edge_threshold: streams small and extreme images through the block
// and checks every edge word against a behavioral predictor kept in this file.
// Depends on set_pkg and the sobel_edge_threshold RTL only.
`timescale 1ns / 1ps

module tb_top;
  import set_pkg::*;

  // Image content styles used to steer the gradients
  typedef enum int {
    SCENE_RANDOM,
    SCENE_FLAT,
    SCENE_CHECKER,
    SCENE_VSTEP,
    SCENE_HSTEP,
    SCENE_BINARY,
    SCENE_SOFT
  } scene_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] pixel
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [7:0] edge_res
  logic                 out_tlast;  // last_in_run
  logic                 out_tuser;  // [0] frame_done
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Predictor state: registers, two line stores, window and raster position
  logic [CFG_W_W-1:0] width_reg;
  logic [HGT_W-1:0]   height_reg;
  logic [THR_W-1:0]   thresh_reg;
  pix_t               row_m2 [MAX_WIDTH];
  pix_t               row_m1 [MAX_WIDTH];
  col_t               window_cols [3];  // oldest column first
  int                 raster_x;
  int                 raster_y;
  res_t               edges_due [$];

  // Traffic shaping and bookkeeping
  bit src_gaps;
  bit sink_gaps;
  int hold_request;
  int mismatches    = 0;
  int pixels_sent   = 0;
  int frames_sent   = 0;
  int words_checked = 0;
  int edges_on      = 0;

  sobel_edge_threshold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // Exact threshold test: gx2^2 + 4*gy^2 (gx2 the 3/6/3 sum) against 4*floor(T/2)^2
  function automatic pix_t edge_decision(col_t lf, col_t cn, col_t rt);
    int gx2, gy, m4, k;
    gx2 = 3 * (int'(lf.top) - int'(rt.top)) + 6 * (int'(lf.mid) - int'(rt.mid))
        + 3 * (int'(lf.bot) - int'(rt.bot));
    gy  = (int'(lf.top) + 2 * int'(cn.top) + int'(rt.top))
        - (int'(lf.bot) + 2 * int'(cn.bot) + int'(rt.bot));
    m4  = gx2 * gx2 + 4 * gy * gy;
    k   = int'(thresh_reg) >> 1;
    return (m4 > 4 * k * k) ? EDGE_ON : EDGE_OFF;
  endfunction

  // Advance the raster by one accepted pixel and queue the edge words it causes
  function automatic void raster_step(pix_t p);
    int   w, h, x, y;
    bit   flush, last;
    pix_t top, mid, bot;
    res_t r;
    w     = eff_width();
    h     = eff_height();
    x     = (raster_x >= w) ? w - 1 : raster_x;
    y     = raster_y;
    flush = (y >= h);
    last  = (x == w - 1);

    // Top and middle rows replicate at the upper border, bottom row in the flush row
    mid       = row_m1[x];
    top       = (y <= 1) ? mid : row_m2[x];
    bot       = flush ? mid : p;
    row_m2[x] = mid;
    row_m1[x] = p;

    window_cols[0] = window_cols[1];
    window_cols[1] = window_cols[2];
    window_cols[2] = '{top: top, mid: mid, bot: bot};

    if (y >= 1) begin
      // Previous column, left edge replicated when it is the first column
      if (x >= 1) begin
        r.edge_res    = edge_decision((x == 1) ? window_cols[1] : window_cols[0],
                                      window_cols[1], window_cols[2]);
        r.last_in_run = !last;
        r.frame_done  = 1'b0;
        edges_due.push_back(r);
      end
      // Last column, right edge replicated
      if (last) begin
        r.edge_res    = edge_decision((x == 0) ? window_cols[2] : window_cols[1],
                                      window_cols[2], window_cols[2]);
        r.last_in_run = 1'b1;
        r.frame_done  = flush;
        edges_due.push_back(r);
      end
    end

    if (last) begin
      raster_x = 0;
      raster_y = flush ? 0 : ((y + 1) & 16'hFFFF);
    end else begin
      raster_x = x + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t: mismatch at result word %0d: %s", $time, words_checked, what);
  endtask

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk) begin : edge_checker
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (edges_due.size() == 0) begin
        report_mismatch($sformatf("word %0h arrived with nothing expected", out_tdata));
      end else begin
        want = edges_due.pop_front();
        if (out_tdata !== want.edge_res)
          report_mismatch($sformatf("edge %0h, want %0h", out_tdata, want.edge_res));
        if (out_tlast !== want.last_in_run)
          report_mismatch($sformatf("tlast %b, want %b", out_tlast, want.last_in_run));
        if (out_tuser !== want.frame_done)
          report_mismatch($sformatf("frame done %b, want %b", out_tuser, want.frame_done));
        words_checked++;
        if (want.edge_res == EDGE_ON) edges_on++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus long hold-offs on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_request > 0) begin
        stall_left   = hold_request - 1;
        hold_request = 0;
        out_tready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pix_t scene_pixel(scene_t s, int x, int y, int w, int h, pix_t base);
    case (s)
      SCENE_FLAT:    return base;
      SCENE_CHECKER: return ((x + y) % 2 == 1) ? 8'd255 : 8'd0;
      SCENE_VSTEP:   return (2 * x < w) ? base : ~base;
      SCENE_HSTEP:   return (2 * y < h) ? base : ~base;
      SCENE_BINARY:  return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
      SCENE_SOFT:    return pix_t'(base + $urandom_range(0, 15));  // faint texture
      default:       return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic wait_for_drain();
    while (edges_due.size() != 0) @(posedge clk);
  endtask

  // Offer one pixel word, optionally after a gap, and hold it until taken
  task automatic send_pixel(pix_t p);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    raster_step(p);
    pixels_sent++;
  endtask

  // Drop valid after the last word of a burst
  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one image plus its flush row; optionally stop mid-image until all words are back
  task automatic send_frame(scene_t scene, int pause_at = -1);
    int   w, h;
    pix_t base;
    w    = eff_width();
    h    = eff_height();
    base = pix_t'($urandom_range(0, 255));
    for (int y = 0; y <= h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (y * w + x == pause_at) begin
          end_burst();
          wait_for_drain();
        end
        send_pixel(scene_pixel(scene, x, y, w, h, base));
      end
    end
    end_burst();
    frames_sent++;
  endtask

  // Write width, height and threshold once the block has gone idle
  task automatic program_image(int w, int h, int t);
    logic [CFG_DAT_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0] idx  [3];
    vals = '{CFG_DAT_W'(w), CFG_DAT_W'(h), CFG_DAT_W'(t)};
    idx  = '{REG_WIDTH, REG_HEIGHT, REG_THRESHOLD};
    wait_for_drain();
    repeat (8) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_WIDTH:     width_reg  = vals[i][CFG_W_W-1:0];
        REG_HEIGHT:    height_reg = vals[i][HGT_W-1:0];
        REG_THRESHOLD: thresh_reg = vals[i][THR_W-1:0];
        default:       ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One-pixel, one-row and one-column images, zero sizes acting as one
  task automatic test_tiny_images();
    program_image(0, 0, 0);
    send_frame(SCENE_BINARY);
    program_image(1, 1, 1);
    send_frame(SCENE_RANDOM);
    program_image(2, 1, 0);
    send_frame(SCENE_CHECKER);
    program_image(1, 3, 0);
    send_frame(SCENE_HSTEP);
  endtask

  // Flat areas never mark an edge, full-swing patterns against the threshold extremes
  task automatic test_threshold_extremes();
    program_image(4, 3, 0);
    send_frame(SCENE_FLAT);
    program_image(4, 3, 0);
    send_frame(SCENE_SOFT);
    program_image(4, 3, 1);
    send_frame(SCENE_CHECKER);
    program_image(5, 3, 2047);
    send_frame(SCENE_CHECKER);
    program_image(5, 2, 2047);
    send_frame(SCENE_BINARY);
  endtask

  // Long sink hold-off fills the result queue; then a mid-image drain pause
  task automatic test_stall_pressure();
    program_image(16, 4, 300);
    hold_request = 150;
    send_frame(SCENE_VSTEP);
    program_image(9, 5, 120);
    send_frame(SCENE_RANDOM, 27);
  endtask

  // Random small images with random thresholds and content
  task automatic test_random_images();
    int start, w, h, t, pick;
    start = pixels_sent;
    while (pixels_sent - start < 110) begin
      w    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
      h    = $urandom_range(1, 4);
      t    = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2047) : $urandom_range(0, 300);
      pick = $urandom_range(0, 9);
      program_image(w, h, t);
      send_frame((pick > 6) ? SCENE_RANDOM : scene_t'(pick));
    end
  endtask

  // Tall image in a single column: every word is both first and last of its row
  task automatic test_tall_column();
    program_image(1, 40, 512);
    send_frame(SCENE_BINARY);
  endtask

  // Several images in sequence, each streamed at full rate
  task automatic test_steady_stream();
    program_image(7, 4, 150);
    send_frame(SCENE_RANDOM);
    program_image(3, 3, 0);
    send_frame(SCENE_CHECKER);
    program_image(11, 2, 900);
    send_frame(SCENE_BINARY);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data  <= '0;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    hold_request = 0;

    // Predictor starts from the reset state
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    thresh_reg = THRESHOLD_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_m2[i] = '0;
      row_m1[i] = '0;
    end
    for (int i = 0; i < 3; i++) window_cols[i] = '0;
    raster_x = 0;
    raster_y = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tiny_images();
    test_threshold_extremes();
    test_stall_pressure();
    test_random_images();

    // Closing stretch runs without gaps on either side
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_tall_column();
    test_steady_stream();

    wait_for_drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d images, %0d pixel words in, %0d edge words checked (%0d edges).",
             frames_sent, pixels_sent, words_checked, edges_on);
    $display("Sizes from one pixel to 32-wide rows and a 40-row column, %s",
             "thresholds 0 to 2047, with stalls and gaps on both sides.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Give up well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d result words still expected", edges_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
